[hdl/fpmc_pkg.sv]
// fpmc_pkg: shared types and constants for the float to PCM mixing converter.
// Used by every module under hdl/; depends on nothing.
package fpmc_pkg;

  localparam logic [2:0] FMT_PCM16  = 3'd0;
  localparam logic [2:0] FMT_LJ24   = 3'd1;
  localparam logic [2:0] FMT_PACK24 = 3'd2;
  localparam logic [2:0] FMT_PCM32  = 3'd3;
  localparam logic [2:0] FMT_FLOAT  = 3'd4;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_MIX    = 1'b1;

  // magnitude bits of IEEE single 1.0
  localparam logic [30:0] ONE_MAG = 31'h3F80_0000;

  localparam int STAGES = 7;

  // unpacked single: effective exponent (1 for subnormals) and mantissa with hidden bit
  typedef struct packed {
    logic        sgn;
    logic [7:0]  ex;
    logic [23:0] man;
  } fpx_t;

  localparam fpx_t FPX_ZERO = '{sgn: 1'b0, ex: 8'd1, man: 24'd0};

endpackage

[hdl/fpmc_unpack.sv]
// fpmc_unpack: two stages; sanitises the new sample and turns the existing word
// into an unpacked single (integer to float with round to nearest even). Uses fpmc_pkg.
module fpmc_unpack (
  input  logic                clk,
  input  logic [1:0]          en,
  input  logic [2:0]          fmt,
  input  logic                mix,
  input  logic [31:0]         new_sample,
  input  logic [31:0]         existing_word,
  output fpmc_pkg::fpx_t      va,
  output fpmc_pkg::fpx_t      ea
);

  function automatic fpmc_pkg::fpx_t sanitize(input logic [31:0] b);
    fpmc_pkg::fpx_t r;
    r = fpmc_pkg::FPX_ZERO;
    if (b[30:23] == 8'hFF) begin
      r = fpmc_pkg::FPX_ZERO;
    end else if (b[30:0] > fpmc_pkg::ONE_MAG) begin
      r.sgn = b[31];
      r.ex  = 8'd127;
      r.man = 24'h80_0000;
    end else begin
      r.sgn = b[31];
      r.ex  = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
      r.man = {(b[30:23] != 8'd0), b[22:0]};
    end
    return r;
  endfunction

  // stage 1
  fpmc_pkg::fpx_t v1;
  fpmc_pkg::fpx_t ef1;
  logic           isint1;
  logic           neg1;
  logic [31:0]    mag1;
  logic [7:0]     eb1;

  logic [31:0] sx;
  logic        isint;
  logic [7:0]  eb;

  always_comb begin
    sx    = existing_word;
    isint = 1'b1;
    eb    = 8'd127;
    case (fmt)
      fpmc_pkg::FMT_PCM16: begin
        sx = {{16{existing_word[15]}}, existing_word[15:0]};
        eb = 8'd143;
      end
      fpmc_pkg::FMT_PACK24: begin
        sx = {{8{existing_word[23]}}, existing_word[23:0]};
        eb = 8'd135;
      end
      fpmc_pkg::FMT_LJ24, fpmc_pkg::FMT_PCM32: begin
        sx = existing_word;
        eb = 8'd127;
      end
      default: begin
        isint = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      v1     <= sanitize(new_sample);
      neg1   <= sx[31];
      mag1   <= sx[31] ? (~sx + 32'd1) : sx;
      eb1    <= eb;
      isint1 <= isint && mix;
      ef1    <= (mix && fmt == fpmc_pkg::FMT_FLOAT) ? sanitize(existing_word)
                                                    : fpmc_pkg::FPX_ZERO;
    end
  end

  // stage 2: normalise and round the integer
  logic [4:0]     lz;
  logic [31:0]    norm;
  logic           up;
  logic [24:0]    rnd;
  fpmc_pkg::fpx_t ec;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag1[i]) lz = 5'(31 - i);
    end
    norm = mag1 << lz;
    up   = norm[7] & ((|norm[6:0]) | norm[8]);
    rnd  = {1'b0, norm[31:8]} + {24'd0, up};
    ec.sgn = neg1;
    if (rnd[24]) begin
      ec.man = 24'h80_0000;
      ec.ex  = eb1 - {3'd0, lz} + 8'd1;
    end else begin
      ec.man = rnd[23:0];
      ec.ex  = eb1 - {3'd0, lz};
    end
    if (!isint1 || mag1 == 32'd0) ec = ef1;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      va <= v1;
      ea <= ec;
    end
  end

endmodule

[hdl/fpmc_fadd.sv]
// fpmc_fadd: three-stage single-precision adder (align/add, normalise, round),
// subnormals kept. Uses fpmc_pkg.
module fpmc_fadd (
  input  logic           clk,
  input  logic [2:0]     en,
  input  fpmc_pkg::fpx_t a,
  input  fpmc_pkg::fpx_t b,
  output logic [31:0]    sum_bits
);

  // stage 1: swap, align, add
  fpmc_pkg::fpx_t big;
  fpmc_pkg::fpx_t sml;
  logic [7:0]     d;
  logic [52:0]    sh;
  logic [26:0]    bal;
  logic           sub;
  logic [27:0]    s28;

  logic [27:0]    s1;
  logic [7:0]     ex1;
  logic           sgn1;

  always_comb begin
    if ({b.ex, b.man} > {a.ex, a.man}) begin
      big = b;
      sml = a;
    end else begin
      big = a;
      sml = b;
    end
    d   = big.ex - sml.ex;
    sh  = {sml.man, 29'd0} >> d;
    bal = (d >= 8'd27) ? {26'd0, |sml.man} : {sh[52:27], |sh[26:0]};
    sub = a.sgn ^ b.sgn;
    s28 = sub ? ({1'b0, big.man, 3'd0} - {1'b0, bal})
              : ({1'b0, big.man, 3'd0} + {1'b0, bal});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1   <= s28;
      ex1  <= big.ex;
      sgn1 <= (s28 == 28'd0 && sub) ? 1'b0 : big.sgn;
    end
  end

  // stage 2: normalise
  logic [4:0]  lz;
  logic [7:0]  lim;
  logic [7:0]  shl;
  logic [26:0] n27;
  logic [7:0]  exn;

  logic [26:0] n2;
  logic [7:0]  ex2;
  logic        sgn2;

  always_comb begin
    lz = 5'd27;
    for (int i = 0; i < 27; i++) begin
      if (s1[i]) lz = 5'(26 - i);
    end
    lim = ex1 - 8'd1;
    shl = ({3'd0, lz} > lim) ? lim : {3'd0, lz};
    if (s1[27]) begin
      n27 = {s1[27:2], s1[1] | s1[0]};
      exn = ex1 + 8'd1;
    end else begin
      n27 = s1[26:0] << shl;
      exn = ex1 - shl;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      n2   <= n27;
      ex2  <= exn;
      sgn2 <= sgn1;
    end
  end

  // stage 3: round to nearest even and pack
  logic        up;
  logic [24:0] rnd;
  logic [31:0] packed_bits;

  always_comb begin
    up  = n2[2] & (n2[1] | n2[0] | n2[3]);
    rnd = {1'b0, n2[26:3]} + {24'd0, up};
    if (rnd[24]) begin
      packed_bits = {sgn2, ex2 + 8'd1, 23'd0};
    end else begin
      packed_bits = {sgn2, rnd[23] ? ex2 : 8'd0, rnd[22:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_bits <= packed_bits;
    end
  end

endmodule

[hdl/fpmc_quant.sv]
// fpmc_quant: two stages; clamps the sum, scales, rounds half away from zero,
// saturates and places the code for the output format. Uses fpmc_pkg.
module fpmc_quant (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [2:0]  fmt,
  input  logic [31:0] sum_bits,
  output logic [31:0] out_word
);

  // stage 1: scaled magnitude times two, floored
  logic [7:0]  offs;
  logic [7:0]  eef;
  logic [7:0]  t1;
  logic [32:0] w;
  logic [32:0] q;

  logic [31:0] q2;
  logic        sgn1;
  logic        big1;
  logic [31:0] fbits1;

  always_comb begin
    case (fmt)
      fpmc_pkg::FMT_PCM16:                        offs = 8'd143;
      fpmc_pkg::FMT_LJ24, fpmc_pkg::FMT_PACK24:   offs = 8'd135;
      default:                                    offs = 8'd127;
    endcase
    eef = (sum_bits[30:23] == 8'd0) ? 8'd1 : sum_bits[30:23];
    t1  = offs - eef;
    w   = {(sum_bits[30:23] != 8'd0), sum_bits[22:0], 9'd0};
    q   = (t1 >= 8'd33) ? 33'd0 : (w >> t1);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      q2     <= q[31:0];
      sgn1   <= sum_bits[31];
      big1   <= sum_bits[30:0] >= fpmc_pkg::ONE_MAG;
      fbits1 <= (sum_bits[30:0] > fpmc_pkg::ONE_MAG) ? {sum_bits[31], fpmc_pkg::ONE_MAG}
                                                     : sum_bits;
    end
  end

  // stage 2: round, sign, saturate, place
  logic [32:0] rs;
  logic [31:0] mag;
  logic [31:0] hi;
  logic [31:0] code;
  logic [31:0] word;

  always_comb begin
    rs  = {1'b0, q2} + 33'd1;
    mag = rs[32:1];
    case (fmt)
      fpmc_pkg::FMT_PCM16:                        hi = 32'h0000_7FFF;
      fpmc_pkg::FMT_LJ24, fpmc_pkg::FMT_PACK24:   hi = 32'h007F_FFFF;
      default:                                    hi = 32'h7FFF_FFFF;
    endcase
    if (big1)           code = sgn1 ? ~hi : hi;
    else if (sgn1)      code = ~mag + 32'd1;
    else if (mag > hi)  code = hi;
    else                code = mag;
    case (fmt)
      fpmc_pkg::FMT_PCM16:  word = {16'd0, code[15:0]};
      fpmc_pkg::FMT_LJ24:   word = {code[23:0], 8'd0};
      fpmc_pkg::FMT_PACK24: word = {8'd0, code[23:0]};
      fpmc_pkg::FMT_PCM32:  word = code;
      fpmc_pkg::FMT_FLOAT:  word = fbits1;
      default:              word = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      out_word <= word;
    end
  end

endmodule

[hdl/float_to_pcm_mixing_converter.sv]
// float_to_pcm_mixing_converter: top level; APB registers, stage valids and the
// unpack, add and quantise sections. Uses fpmc_pkg, fpmc_unpack, fpmc_fadd, fpmc_quant.
//
//   channel  | handshake                    | payload
//   sample   | sample_valid / sample_ready  | new_sample, existing_word, last_in
//   result   | result_valid / result_ready  | out_word, last_out
//   apb      | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// Seven register stages, one word per cycle while results are taken.
// Each stage holds its own valid; a stage moves when it is empty or the one after
// it moves, so bubbles close up and a stalled result stops intake only once all
// seven stages are full.
// rst clears the valids and the registers (format pcm16, mixing off).
module float_to_pcm_mixing_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        sample_valid,
  output logic        sample_ready,
  input  logic [31:0] new_sample,
  input  logic [31:0] existing_word,
  input  logic        last_in,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [31:0] out_word,
  output logic        last_out
);

  localparam int N = fpmc_pkg::STAGES;

  logic [2:0] fmt;
  logic       mix;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fmt <= fpmc_pkg::FMT_PCM16;
      mix <= 1'b0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == fpmc_pkg::REG_FORMAT) fmt <= pwdata[2:0];
      else                                  mix <= pwdata[0];
    end
  end

  assign prdata = (paddr[2] == fpmc_pkg::REG_MIX) ? {31'd0, mix} : {29'd0, fmt};

  logic [N-1:0] valid;
  logic [N-1:0] last;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !valid[N-1] || result_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int i = 0; i < N; i++) begin
        if (en[i]) valid[i] <= (i == 0) ? sample_valid : valid[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (en[i]) last[i] <= (i == 0) ? last_in : last[(i == 0) ? 0 : i - 1];
    end
  end

  assign sample_ready = en[0];
  assign result_valid = valid[N-1];
  assign last_out     = last[N-1];

  fpmc_pkg::fpx_t va;
  fpmc_pkg::fpx_t ea;
  logic [31:0]    sum_bits;

  fpmc_unpack u_unpack (
    .clk           (clk),
    .en            (en[1:0]),
    .fmt           (fmt),
    .mix           (mix),
    .new_sample    (new_sample),
    .existing_word (existing_word),
    .va            (va),
    .ea            (ea)
  );

  fpmc_fadd u_fadd (
    .clk      (clk),
    .en       (en[4:2]),
    .a        (va),
    .b        (ea),
    .sum_bits (sum_bits)
  );

  fpmc_quant u_quant (
    .clk      (clk),
    .en       (en[6:5]),
    .fmt      (fmt),
    .sum_bits (sum_bits),
    .out_word (out_word)
  );

`ifndef SYNTHESIS
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_ready |=> valid[0])
    else $error("accepted word did not enter first stage");

  a_hold_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(last_out))
    else $error("stalled result lost");

  a_float_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid && fmt == fpmc_pkg::FMT_FLOAT |-> out_word[30:0] <= fpmc_pkg::ONE_MAG)
    else $error("float result outside [-1,1]");

  a_pcm16_high: assert property (@(posedge clk) disable iff (rst)
    result_valid && fmt == fpmc_pkg::FMT_PCM16 |-> out_word[31:16] == 16'd0)
    else $error("pcm16 upper bits set");
`endif

endmodule
